FILE: sv/hsv2rgb_pkg.sv
// shared constants and types for the hsv to rgb converter
package hsv2rgb_pkg;

  localparam int HueW  = 13;
  localparam int UnitW = 9;
  localparam int ChanW = 8;
  localparam int RemW  = 10;
  localparam int SectW = 3;

  localparam logic [HueW-1:0]  HueFull   = 13'd5760;
  localparam logic [HueW-1:0]  HueSector = 13'd960;
  localparam logic [UnitW-1:0] UnitOne   = 9'd256;

  // floor(x / 15) == (x * 4370) >> 16 for x < 3840, so rem * 256 / 960 uses 4 * 4370
  localparam logic [14:0] FracRecip = 15'd17480;

  localparam logic [SectW-1:0] SectRedRise   = 3'd0;
  localparam logic [SectW-1:0] SectGreenFall = 3'd1;
  localparam logic [SectW-1:0] SectGreenRise = 3'd2;
  localparam logic [SectW-1:0] SectBlueFall  = 3'd3;
  localparam logic [SectW-1:0] SectBlueRise  = 3'd4;
  localparam logic [SectW-1:0] SectRedFall   = 3'd5;
  localparam logic [SectW-1:0] SectNone      = 3'd6;

  typedef struct packed {
    logic [SectW-1:0] sector;
    logic [RemW-1:0]  rem;
    logic             over;
  } hue_dec_t;

endpackage

FILE: sv/hsv2rgb_hue_decode.sv
// hue wrap, sector index and remainder within the sector
module hsv2rgb_hue_decode (
  input  logic [hsv2rgb_pkg::HueW-1:0] hue_i,
  output hsv2rgb_pkg::hue_dec_t        dec_o
);

  logic [hsv2rgb_pkg::HueW-1:0] hue_w;
  logic [hsv2rgb_pkg::HueW-1:0] base;
  logic [hsv2rgb_pkg::HueW-1:0] diff;

  always_comb begin
    hue_w = (hue_i == hsv2rgb_pkg::HueFull) ? '0 : hue_i;
    dec_o.over = 1'b0;
    if (hue_w < hsv2rgb_pkg::HueSector) begin
      dec_o.sector = hsv2rgb_pkg::SectRedRise;
      base = '0;
    end else if (hue_w < 13'(2 * hsv2rgb_pkg::HueSector)) begin
      dec_o.sector = hsv2rgb_pkg::SectGreenFall;
      base = hsv2rgb_pkg::HueSector;
    end else if (hue_w < 13'(3 * hsv2rgb_pkg::HueSector)) begin
      dec_o.sector = hsv2rgb_pkg::SectGreenRise;
      base = 13'(2 * hsv2rgb_pkg::HueSector);
    end else if (hue_w < 13'(4 * hsv2rgb_pkg::HueSector)) begin
      dec_o.sector = hsv2rgb_pkg::SectBlueFall;
      base = 13'(3 * hsv2rgb_pkg::HueSector);
    end else if (hue_w < 13'(5 * hsv2rgb_pkg::HueSector)) begin
      dec_o.sector = hsv2rgb_pkg::SectBlueRise;
      base = 13'(4 * hsv2rgb_pkg::HueSector);
    end else if (hue_w < hsv2rgb_pkg::HueFull) begin
      dec_o.sector = hsv2rgb_pkg::SectRedFall;
      base = 13'(5 * hsv2rgb_pkg::HueSector);
    end else begin
      dec_o.sector = hsv2rgb_pkg::SectNone;
      dec_o.over = 1'b1;
      base = hue_w;
    end
    diff = hue_w - base;
    dec_o.rem = diff[hsv2rgb_pkg::RemW-1:0];
  end

endmodule

FILE: sv/hsv_to_rgb_converter_core.sv
// five stage pipelined hsv to rgb converter top level
// five register stages lie between input transfer and result valid
// throughput: one transfer per cycle, every stage takes a new item each cycle unless stalled
// each stage stalls only when it holds data and the stage after it is stalled
// reset clears the stage valid bits, data registers are not reset
module hsv_to_rgb_converter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]   hue_i,
  input  logic [hsv2rgb_pkg::UnitW-1:0]  saturation_i,
  input  logic [hsv2rgb_pkg::UnitW-1:0]  brightness_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]  red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]  green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]  blue_o
);

  localparam int UW = hsv2rgb_pkg::UnitW;
  localparam int CW = hsv2rgb_pkg::ChanW;
  localparam int SW = hsv2rgb_pkg::SectW;

  logic [4:0] vld_q;
  logic [4:0] vld_d;
  logic [4:0] rdy;

  hsv2rgb_pkg::hue_dec_t dec;

  logic [UW-1:0] sat_c;
  logic [UW-1:0] val_c;

  // stage 1
  logic [UW-1:0]               s1_sat_q, s1_val_q;
  logic [SW-1:0]               s1_sector_q;
  logic [hsv2rgb_pkg::RemW-1:0] s1_rem_q;
  logic                        s1_black_q;
  // stage 2
  logic [24:0]   frac_prod;
  logic [15:0]   full_prod;
  logic [UW-1:0] s2_sat_q, s2_val_q;
  logic [7:0]    s2_frac_q;
  logic [16:0]   s2_vs_q;
  logic [CW-1:0] s2_full_q;
  logic [SW-1:0] s2_sector_q;
  logic          s2_black_q;
  // stage 3
  logic [24:0]   lo_prod;
  logic [UW-1:0] s3_val_q;
  logic [16:0]   s3_sf_q, s3_snf_q;
  logic [CW-1:0] s3_full_q, s3_lo_q;
  logic [SW-1:0] s3_sector_q;
  logic          s3_black_q;
  // stage 4
  logic [25:0]   s4_fall_q, s4_rise_q;
  logic [CW-1:0] s4_full_q, s4_lo_q;
  logic [SW-1:0] s4_sector_q;
  logic          s4_black_q;
  // stage 5
  logic [33:0]   fall_prod, rise_prod;
  logic [CW-1:0] fall_c, rise_c;
  logic [CW-1:0] red_d, green_d, blue_d;
  logic [CW-1:0] red_q, green_q, blue_q;

  hsv2rgb_hue_decode u_hue_decode (
    .hue_i (hue_i),
    .dec_o (dec)
  );

  // per stage flow control
  always_comb begin
    rdy[4] = !vld_q[4] || !out_stall_i;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < 5; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[4];

  // clamp to 1.0
  assign sat_c = (saturation_i > hsv2rgb_pkg::UnitOne) ? hsv2rgb_pkg::UnitOne : saturation_i;
  assign val_c = (brightness_i > hsv2rgb_pkg::UnitOne) ? hsv2rgb_pkg::UnitOne : brightness_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_sat_q    <= sat_c;
      s1_val_q    <= val_c;
      s1_sector_q <= dec.sector;
      s1_rem_q    <= dec.rem;
      s1_black_q  <= dec.over && (sat_c != '0);
    end
  end

  assign frac_prod = 25'(s1_rem_q) * 25'(hsv2rgb_pkg::FracRecip);
  assign full_prod = 16'(s1_val_q) * 16'd255;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_sat_q    <= s1_sat_q;
      s2_val_q    <= s1_val_q;
      s2_frac_q   <= frac_prod[23:16];
      s2_vs_q     <= 17'(s1_val_q) * (17'(hsv2rgb_pkg::UnitOne) - 17'(s1_sat_q));
      s2_full_q   <= full_prod[15:8];
      s2_sector_q <= s1_sector_q;
      s2_black_q  <= s1_black_q;
    end
  end

  assign lo_prod = 25'(s2_vs_q) * 25'd255;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_val_q    <= s2_val_q;
      s3_sf_q     <= 17'(s2_sat_q) * 17'(s2_frac_q);
      s3_snf_q    <= 17'(s2_sat_q) * (17'(hsv2rgb_pkg::UnitOne) - 17'(s2_frac_q));
      s3_full_q   <= s2_full_q;
      s3_lo_q     <= lo_prod[23:16];
      s3_sector_q <= s2_sector_q;
      s3_black_q  <= s2_black_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_fall_q   <= 26'(s3_val_q) * (26'd65536 - 26'(s3_sf_q));
      s4_rise_q   <= 26'(s3_val_q) * (26'd65536 - 26'(s3_snf_q));
      s4_full_q   <= s3_full_q;
      s4_lo_q     <= s3_lo_q;
      s4_sector_q <= s3_sector_q;
      s4_black_q  <= s3_black_q;
    end
  end

  assign fall_prod = 34'(s4_fall_q) * 34'd255;
  assign rise_prod = 34'(s4_rise_q) * 34'd255;
  assign fall_c    = fall_prod[31:24];
  assign rise_c    = rise_prod[31:24];

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    if (!s4_black_q) begin
      case (s4_sector_q)
        hsv2rgb_pkg::SectRedRise: begin
          red_d = s4_full_q; green_d = rise_c; blue_d = s4_lo_q;
        end
        hsv2rgb_pkg::SectGreenFall: begin
          red_d = fall_c; green_d = s4_full_q; blue_d = s4_lo_q;
        end
        hsv2rgb_pkg::SectGreenRise: begin
          red_d = s4_lo_q; green_d = s4_full_q; blue_d = rise_c;
        end
        hsv2rgb_pkg::SectBlueFall: begin
          red_d = s4_lo_q; green_d = fall_c; blue_d = s4_full_q;
        end
        hsv2rgb_pkg::SectBlueRise: begin
          red_d = rise_c; green_d = s4_lo_q; blue_d = s4_full_q;
        end
        hsv2rgb_pkg::SectRedFall: begin
          red_d = s4_full_q; green_d = s4_lo_q; blue_d = fall_c;
        end
        default: begin
          // over-range hue with zero saturation stays grey
          red_d = s4_full_q; green_d = s4_full_q; blue_d = s4_full_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

FILE: verif/hsv_to_rgb_converter_checker.sv
`timescale 1ns / 1ps
// checker that predicts each color conversion and compares it with the block output
module hsv_to_rgb_converter_checker
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [UnitW-1:0] saturation_i,
  input  logic [UnitW-1:0] brightness_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  rgb_t rgb_q[$];
  int   fails;
  int   waiting;

  function automatic rgb_t convert_hsv(logic [HueW-1:0] hue, logic [UnitW-1:0] sat_raw,
                                       logic [UnitW-1:0] val_raw);
    logic [UnitW-1:0] s;
    logic [UnitW-1:0] v;
    int               hv;
    int               frac;
    logic [SectW-1:0] sect;
    logic [39:0]      prod;
    logic [ChanW-1:0] full;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] fall;
    logic [ChanW-1:0] rise;
    rgb_t             px;
    s = (sat_raw > UnitOne) ? UnitOne : sat_raw;
    v = (val_raw > UnitOne) ? UnitOne : val_raw;
    prod = 40'(v) * 40'd255;
    full = prod[15:8];
    hv = (hue == HueFull) ? 0 : int'(hue);
    if (s == '0) begin
      px = {full, full, full};
    end else if (hv > int'(HueFull)) begin
      px = '0;
    end else begin
      sect = SectW'(hv / int'(HueSector));
      frac = ((hv % int'(HueSector)) * 256) / int'(HueSector);
      prod = 40'(v) * 40'(UnitOne - s) * 40'd255;
      lo = prod[23:16];
      prod = 40'(v) * (40'd65536 - 40'(s) * 40'(frac)) * 40'd255;
      fall = prod[31:24];
      prod = 40'(v) * (40'd65536 - 40'(s) * (40'd256 - 40'(frac))) * 40'd255;
      rise = prod[31:24];
      case (sect)
        SectRedRise:   px = {full, rise, lo};
        SectGreenFall: px = {fall, full, lo};
        SectGreenRise: px = {lo, full, rise};
        SectBlueFall:  px = {lo, fall, full};
        SectBlueRise:  px = {rise, lo, full};
        SectRedFall:   px = {full, lo, fall};
        default:       px = '0;
      endcase
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      rgb_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rgb_q.size() == 0) begin
          $error("result transfer with no pixel waiting: red %0d green %0d blue %0d",
                 red_i, green_i, blue_i);
          fails++;
        end else begin
          want = rgb_q.pop_front();
          if (red_i !== want.red) begin
            $error("red mismatch: expected %0d, actual %0d", want.red, red_i);
            fails++;
          end
          if (green_i !== want.green) begin
            $error("green mismatch: expected %0d, actual %0d", want.green, green_i);
            fails++;
          end
          if (blue_i !== want.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", want.blue, blue_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rgb_q.push_back(convert_hsv(hue_i, saturation_i, brightness_i));
      end
    end
    waiting = rgb_q.size();
  end

  assign fail_count_o = fails;
  assign pending_o    = waiting;

endmodule

FILE: verif/tb_hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// testbench top that drives pixel transfers into the hsv to rgb converter and gives the verdict
module tb_hsv_to_rgb_converter_core;
  import hsv2rgb_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int HoldCycles    = 64;
  localparam int DrainCycles   = 20;
  localparam int PhaseItems    = 460;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic [HueW-1:0]  hue        = '0;
  logic [UnitW-1:0] saturation = '0;
  logic [UnitW-1:0] brightness = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int fail_count;
  int pending;

  initial begin
    forever #5 clk = ~clk;
  end

  hsv_to_rgb_converter_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .hue_i        (hue),
    .saturation_i (saturation),
    .brightness_i (brightness),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  hsv_to_rgb_converter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .hue_i        (hue),
    .saturation_i (saturation),
    .brightness_i (brightness),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        left = HoldCycles;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_hsv(input logic [HueW-1:0] h, input logic [UnitW-1:0] s,
                          input logic [UnitW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [UnitW-1:0] rand_unit();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return UnitOne;
      2:       return UnitW'($urandom_range(257, 511));
      default: return UnitW'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_random();
    logic [HueW-1:0] h;
    case ($urandom_range(0, 9))
      0:       h = HueW'($urandom_range(int'(HueFull) + 1, 8191));
      1:       h = HueW'($urandom_range(1, 6) * int'(HueSector) - $urandom_range(0, 1));
      default: h = HueW'($urandom_range(0, int'(HueFull) - 1));
    endcase
    send_hsv(h, rand_unit(), rand_unit());
  endtask

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 83, 0, 7};
    recv_pcts = '{0, 0, 83, 7};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sector edges, wrap at full circle, beyond full circle, grey and clamping
    send_hsv(0, 256, 256);
    send_hsv(480, 256, 256);
    send_hsv(959, 256, 256);
    send_hsv(960, 256, 256);
    send_hsv(1920, 256, 256);
    send_hsv(2880, 256, 256);
    send_hsv(3840, 256, 256);
    send_hsv(4800, 256, 256);
    send_hsv(5759, 256, 256);
    send_hsv(5760, 256, 256);
    send_hsv(5761, 256, 256);
    send_hsv(8191, 256, 256);
    send_hsv(8191, 0, 256);
    send_hsv(7000, 100, 100);
    send_hsv(1000, 0, 200);
    send_hsv(0, 0, 0);
    send_hsv(0, 256, 0);
    send_hsv(3000, 511, 511);
    send_hsv(4000, 257, 300);
    send_hsv(2000, 128, 128);
    send_hsv(500, 1, 255);
    send_hsv(5000, 255, 1);

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    repeat (40) send_random();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      repeat (PhaseItems) send_random();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
